### rtl/rrpc_pkg.sv
package rrpc_pkg;

  // Coordinate width: covers pixel minus rectangle origin and all derived bounds.
  localparam int unsigned CW = 13;

  localparam logic [11:0] SCREEN_WIDTH  = 12'd800;
  localparam logic [11:0] SCREEN_HEIGHT = 12'd480;

  // One root bit per chain cell; the operand is at most r*r with r <= 204.
  localparam int unsigned SQRT_STEPS = 8;
  localparam int unsigned ROOT_W     = SQRT_STEPS;
  localparam int unsigned OPND_W     = 2 * SQRT_STEPS;
  localparam int unsigned REM_W      = SQRT_STEPS + 2;

  // floor(m / 10) == (m * RECIP10) >> RECIP_SHIFT for every 11-bit m.
  localparam logic [12:0] RECIP10     = 13'd6554;
  localparam int unsigned RECIP_SHIFT = 16;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECT_LEFT,
    REG_RECT_TOP,
    REG_RECT_WIDTH,
    REG_RECT_HEIGHT,
    REG_DRAW_MODE,
    REG_TONE,
    REG_ROUND_CORNERS
  } rrpc_reg_e;

  typedef enum logic [1:0] {
    MODE_SOLID,
    MODE_DASHED,
    MODE_FILL
  } rrpc_mode_e;

  typedef enum logic [1:0] {
    TONE_PAPER,
    TONE_INK,
    TONE_GRAY
  } rrpc_tone_e;

  typedef logic signed [CW-1:0] rrpc_coord_t;

  typedef struct packed {
    logic signed [11:0] left;
    logic signed [11:0] top;
    logic [10:0]        width;
    logic [10:0]        height;
    logic [1:0]         mode;
    logic [1:0]         tone;
    logic               round;
    logic [ROOT_W-1:0]  rad;    // corner radius
    rrpc_coord_t        wm1;    // width - 1
    rrpc_coord_t        hmt;    // height - 1 + top
    rrpc_coord_t        wr1;    // width - radius - 1
  } rrpc_cfg_t;

  typedef struct packed {
    rrpc_coord_t dx;
    rrpc_coord_t dy;
    logic [8:0]  py;
    logic        onscr;
    logic        par;
  } rrpc_p1_t;

  typedef struct packed {
    rrpc_coord_t dx;
    rrpc_coord_t dy;
    rrpc_coord_t hb;    // height - 1 - dy
    rrpc_coord_t t_lo;  // radius - dx
    logic        onscr;
    logic        par;
  } rrpc_p2_t;

  typedef struct packed {
    rrpc_coord_t t_lo;
    rrpc_coord_t t_hi;  // dx - (width - radius - 1)
    logic        base_hit;
    logic        arc_a;
    logic        arc_b;
    logic        fill_a;
    logic        fill_b;
    logic        val;
  } rrpc_side_t;

  typedef struct packed {
    rrpc_side_t        side;
    logic [ROOT_W-1:0] h_a;
    logic [ROOT_W:0]   k_a;
    logic [ROOT_W-1:0] h_b;
    logic [ROOT_W:0]   k_b;
  } rrpc_p3_t;

  typedef struct packed {
    logic [OPND_W-1:0] opnd;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } rrpc_root_t;

  typedef struct packed {
    rrpc_side_t side;
    rrpc_root_t lane_a;
    rrpc_root_t lane_b;
  } rrpc_item_t;

endpackage

### rtl/rounded_rect_pixel_coverage_unit.sv
// Rounded rectangle pixel coverage.
// Program the rectangle through the write port (cfg_we_i, cfg_index_i,
// cfg_wdata_i), one register per write, only while no item is in flight.
// Each item on the input channel is one raster pixel (pixel_x_i, pixel_y_i);
// each item on the output channel tells whether the shape covers it
// (covered_o) and the value it writes (pixel_value_o, 0 when not covered).
// Both channels use valid/ready; results leave in input order.
// Between the accepting edge and out_valid_o lie four setup stages (offsets,
// bounds, edge tests, span operands), eight square-root cells that each
// resolve one bit of the two corner spans, and the output register.
// Throughput is one pixel per clock while the receiver does not stall.
// When the receiver stalls, the stages fill one by one behind the output
// register; in_ready_o drops only once every stage holds an item.
// Reset empties the pipeline and loads the register defaults: zero origin
// and size (nothing drawn), solid outline, ink tone, square corners.
module rounded_rect_pixel_coverage_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rrpc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rrpc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [9:0]                      pixel_x_i,
  input  logic [8:0]                      pixel_y_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            covered_o,
  output logic                            pixel_value_o
);
  import rrpc_pkg::*;

  rrpc_cfg_t             cfg;
  logic [SQRT_STEPS:0]   chain_valid;
  logic [SQRT_STEPS:0]   chain_ready;
  rrpc_item_t            chain_item [SQRT_STEPS+1];

  rrpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rrpc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .dn_valid_o (chain_valid[0]),
    .dn_item_o  (chain_item[0]),
    .dn_ready_i (chain_ready[0])
  );

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_cell
    rrpc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .up_valid_i (chain_valid[i]),
      .up_item_i  (chain_item[i]),
      .up_ready_o (chain_ready[i]),
      .dn_valid_o (chain_valid[i+1]),
      .dn_item_o  (chain_item[i+1]),
      .dn_ready_i (chain_ready[i+1])
    );
  end

  rrpc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .up_valid_i    (chain_valid[SQRT_STEPS]),
    .up_item_i     (chain_item[SQRT_STEPS]),
    .up_ready_o    (chain_ready[SQRT_STEPS]),
    .out_valid_o   (out_valid_o),
    .covered_o     (covered_o),
    .pixel_value_o (pixel_value_o),
    .out_ready_i   (out_ready_i)
  );

endmodule

### rtl/rrpc_cfg.sv
module rrpc_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rrpc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rrpc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output rrpc_pkg::rrpc_cfg_t            cfg_o
);
  import rrpc_pkg::*;

  logic signed [11:0] left_q, top_q;
  logic [10:0]        width_q, height_q;
  logic [1:0]         mode_q, tone_q;
  logic               round_q;
  logic [ROOT_W-1:0]  rad_q, rad_d;
  rrpc_coord_t        wm1_q, wm1_d, hmt_q, hmt_d, wr1_q, wr1_d;

  logic [10:0]        side_min;
  logic [23:0]        prod;
  logic [ROOT_W-1:0]  tenth;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
      mode_q   <= MODE_SOLID;
      tone_q   <= TONE_INK;
      round_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (rrpc_reg_e'(cfg_index_i))
        REG_RECT_LEFT:     left_q   <= cfg_wdata_i[11:0];
        REG_RECT_TOP:      top_q    <= cfg_wdata_i[11:0];
        REG_RECT_WIDTH:    width_q  <= cfg_wdata_i[10:0];
        REG_RECT_HEIGHT:   height_q <= cfg_wdata_i[10:0];
        REG_DRAW_MODE:     mode_q   <= cfg_wdata_i[1:0];
        REG_TONE:          tone_q   <= cfg_wdata_i[1:0];
        REG_ROUND_CORNERS: round_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Radius: 1 below five pixels, else max(2, m/10); m/10 never exceeds m/2 there.
  assign side_min = (width_q < height_q) ? width_q : height_q;
  assign prod     = {13'd0, side_min} * {11'd0, RECIP10};
  assign tenth    = prod[RECIP_SHIFT +: ROOT_W];

  always_comb begin
    if (side_min < 11'd5) begin
      rad_d = ROOT_W'(1);
    end else if (tenth < ROOT_W'(2)) begin
      rad_d = ROOT_W'(2);
    end else begin
      rad_d = tenth;
    end
    wm1_d = rrpc_coord_t'({2'b00, width_q} - 13'd1);
    hmt_d = rrpc_coord_t'({2'b00, height_q} - 13'd1 + {top_q[11], top_q});
    wr1_d = rrpc_coord_t'({2'b00, width_q} - {{(CW-ROOT_W){1'b0}}, rad_q} - 13'd1);
  end

  // Derived values trail the raw registers; the front end reads them only in later stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q <= ROOT_W'(1);
      wm1_q <= '0;
      hmt_q <= '0;
      wr1_q <= '0;
    end else begin
      rad_q <= rad_d;
      wm1_q <= wm1_d;
      hmt_q <= hmt_d;
      wr1_q <= wr1_d;
    end
  end

  always_comb begin
    cfg_o.left   = left_q;
    cfg_o.top    = top_q;
    cfg_o.width  = width_q;
    cfg_o.height = height_q;
    cfg_o.mode   = mode_q;
    cfg_o.tone   = tone_q;
    cfg_o.round  = round_q;
    cfg_o.rad    = rad_q;
    cfg_o.wm1    = wm1_q;
    cfg_o.hmt    = hmt_q;
    cfg_o.wr1    = wr1_q;
  end

endmodule

### rtl/rrpc_front.sv
module rrpc_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rrpc_pkg::rrpc_cfg_t  cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [9:0]           pixel_x_i,
  input  logic [8:0]           pixel_y_i,
  output logic                 dn_valid_o,
  output rrpc_pkg::rrpc_item_t dn_item_o,
  input  logic                 dn_ready_i
);
  import rrpc_pkg::*;

  logic       v1_q, v2_q, v3_q, v4_q;
  logic       rdy1, rdy2, rdy3, rdy4;
  rrpc_p1_t   p1_q, p1_d;
  rrpc_p2_t   p2_q, p2_d;
  rrpc_p3_t   p3_q, p3_d;
  rrpc_item_t p4_q, p4_d;

  rrpc_coord_t       wid_c, hgt_c, rad_c;
  logic              gate, dx_in, dy_in, inbox, row_edge, col_edge;
  logic              sq_out, rd_out, dash, rd_fill;
  logic              is_solid, is_fill;
  logic [2*ROOT_W:0] prod_a, prod_b;

  // Each stage moves when it is empty or its successor moves.
  assign rdy4       = !v4_q || dn_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;
  assign dn_valid_o = v4_q;
  assign dn_item_o  = p4_q;

  // Stage 1: offsets from the raw origin registers, on-screen test and pixel parity.
  always_comb begin
    p1_d.dx    = rrpc_coord_t'({3'b000, pixel_x_i} - {cfg_i.left[11], cfg_i.left});
    p1_d.dy    = rrpc_coord_t'({4'b0000, pixel_y_i} - {cfg_i.top[11], cfg_i.top});
    p1_d.py    = pixel_y_i;
    p1_d.onscr = ({2'b00, pixel_x_i} < SCREEN_WIDTH) && ({3'b000, pixel_y_i} < SCREEN_HEIGHT);
    p1_d.par   = pixel_x_i[0] ^ pixel_y_i[0];
  end

  // Stage 2: distance from the bottom row and left corner bound.
  always_comb begin
    p2_d.dx    = p1_q.dx;
    p2_d.dy    = p1_q.dy;
    p2_d.hb    = rrpc_coord_t'(cfg_i.hmt - {4'b0000, p1_q.py});
    p2_d.t_lo  = rrpc_coord_t'({{(CW-ROOT_W){1'b0}}, cfg_i.rad} - p1_q.dx);
    p2_d.onscr = p1_q.onscr;
    p2_d.par   = p1_q.par;
  end

  // Stage 3: every test that does not need a corner span.
  always_comb begin
    wid_c    = rrpc_coord_t'({2'b00, cfg_i.width});
    hgt_c    = rrpc_coord_t'({2'b00, cfg_i.height});
    rad_c    = rrpc_coord_t'({{(CW-ROOT_W){1'b0}}, cfg_i.rad});
    gate     = p2_q.onscr && (cfg_i.width != '0) && (cfg_i.height != '0);
    dx_in    = !p2_q.dx[CW-1] && (p2_q.dx < wid_c);
    dy_in    = !p2_q.dy[CW-1] && (p2_q.dy < hgt_c);
    inbox    = dx_in && dy_in;
    row_edge = (p2_q.dy == '0) || (p2_q.hb == '0);
    col_edge = (p2_q.dx == '0) || (p2_q.dx == cfg_i.wm1);
    sq_out   = inbox && (row_edge || col_edge);
    rd_out   = (row_edge && (p2_q.dx > rad_c) && (p2_q.dx < cfg_i.wr1)) ||
               (col_edge && (p2_q.dy > rad_c) && (p2_q.hb > rad_c));
    dash     = inbox && ((row_edge && !p2_q.dx[1]) || (col_edge && !p2_q.dy[1]));
    rd_fill  = dx_in && (p2_q.dy >= rad_c) && (p2_q.hb >= rad_c);
    is_solid = (cfg_i.mode == MODE_SOLID);
    is_fill  = (cfg_i.mode == MODE_FILL);

    p3_d.side.base_hit = 1'b0;
    case (cfg_i.mode)
      MODE_SOLID:  p3_d.side.base_hit = gate && (cfg_i.round ? rd_out : sq_out);
      MODE_DASHED: p3_d.side.base_hit = gate && dash;
      MODE_FILL:   p3_d.side.base_hit = gate && (cfg_i.round ? rd_fill : inbox);
      default:     p3_d.side.base_hit = 1'b0;
    endcase

    p3_d.side.t_lo   = p2_q.t_lo;
    p3_d.side.t_hi   = rrpc_coord_t'(p2_q.dx - cfg_i.wr1);
    p3_d.side.arc_a  = gate && is_solid && cfg_i.round && !p2_q.dy[CW-1] && (p2_q.dy <= rad_c);
    p3_d.side.arc_b  = gate && is_solid && cfg_i.round && !p2_q.hb[CW-1] && (p2_q.hb <= rad_c);
    p3_d.side.fill_a = gate && is_fill && cfg_i.round && !p2_q.dy[CW-1] && (p2_q.dy < rad_c);
    p3_d.side.fill_b = gate && is_fill && cfg_i.round && !p2_q.hb[CW-1] && (p2_q.hb < rad_c);

    // Gray checkerboard only on a square-cornered fill; elsewhere any nonzero tone is ink.
    if (is_fill && !cfg_i.round && (cfg_i.tone == TONE_GRAY)) begin
      p3_d.side.val = !p2_q.par;
    end else begin
      p3_d.side.val = (cfg_i.tone != TONE_PAPER);
    end

    // r*r - (r-h)*(r-h) == h * (2r - h); only meaningful when 0 <= h <= r.
    p3_d.h_a = p2_q.dy[ROOT_W-1:0];
    p3_d.k_a = {cfg_i.rad, 1'b0} - {1'b0, p2_q.dy[ROOT_W-1:0]};
    p3_d.h_b = p2_q.hb[ROOT_W-1:0];
    p3_d.k_b = {cfg_i.rad, 1'b0} - {1'b0, p2_q.hb[ROOT_W-1:0]};
  end

  // Stage 4: square-root operands.
  always_comb begin
    prod_a          = {{(ROOT_W+1){1'b0}}, p3_q.h_a} * {{ROOT_W{1'b0}}, p3_q.k_a};
    prod_b          = {{(ROOT_W+1){1'b0}}, p3_q.h_b} * {{ROOT_W{1'b0}}, p3_q.k_b};
    p4_d.side       = p3_q.side;
    p4_d.lane_a.opnd = prod_a[OPND_W-1:0];
    p4_d.lane_a.rem  = '0;
    p4_d.lane_a.root = '0;
    p4_d.lane_b.opnd = prod_b[OPND_W-1:0];
    p4_d.lane_b.rem  = '0;
    p4_d.lane_b.root = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) p1_q <= p1_d;
    if (rdy2 && v1_q)       p2_q <= p2_d;
    if (rdy3 && v2_q)       p3_q <= p3_d;
    if (rdy4 && v3_q)       p4_q <= p4_d;
  end

endmodule

### rtl/rrpc_cell.sv
module rrpc_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 up_valid_i,
  input  rrpc_pkg::rrpc_item_t up_item_i,
  output logic                 up_ready_o,
  output logic                 dn_valid_o,
  output rrpc_pkg::rrpc_item_t dn_item_o,
  input  logic                 dn_ready_i
);
  import rrpc_pkg::*;

  logic       v_q;
  rrpc_item_t item_q, item_d;

  // One root bit: bring down two operand bits, try subtracting 4*root + 1.
  function automatic rrpc_root_t root_step(input rrpc_root_t cur);
    rrpc_root_t       nxt;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    rem_sh   = {cur.rem[REM_W-3:0], cur.opnd[OPND_W-1 -: 2]};
    trial    = {cur.root, 2'b01};
    nxt.opnd = {cur.opnd[OPND_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      nxt.rem  = rem_sh - trial;
      nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = rem_sh;
      nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

  always_comb begin
    item_d.side   = up_item_i.side;
    item_d.lane_a = root_step(up_item_i.lane_a);
    item_d.lane_b = root_step(up_item_i.lane_b);
  end

  assign up_ready_o = !v_q || dn_ready_i;
  assign dn_valid_o = v_q;
  assign dn_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (up_ready_o) begin
      v_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

### rtl/rrpc_back.sv
module rrpc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 up_valid_i,
  input  rrpc_pkg::rrpc_item_t up_item_i,
  output logic                 up_ready_o,
  output logic                 out_valid_o,
  output logic                 covered_o,
  output logic                 pixel_value_o,
  input  logic                 out_ready_i
);
  import rrpc_pkg::*;

  logic        ov_q, cov_q, val_q;
  logic        cov_d;
  rrpc_coord_t s_a, s_b;
  rrpc_side_t  sd;

  always_comb begin
    sd    = up_item_i.side;
    s_a   = rrpc_coord_t'({{(CW-ROOT_W){1'b0}}, up_item_i.lane_a.root});
    s_b   = rrpc_coord_t'({{(CW-ROOT_W){1'b0}}, up_item_i.lane_b.root});
    // Arc pixel sits at r - span or w - r - 1 + span; fill row spans between them.
    cov_d = sd.base_hit ||
            (sd.arc_a  && ((s_a == sd.t_lo) || (s_a == sd.t_hi))) ||
            (sd.arc_b  && ((s_b == sd.t_lo) || (s_b == sd.t_hi))) ||
            (sd.fill_a && (s_a >= sd.t_lo) && (s_a >= sd.t_hi)) ||
            (sd.fill_b && (s_b >= sd.t_lo) && (s_b >= sd.t_hi));
  end

  assign up_ready_o    = !ov_q || out_ready_i;
  assign out_valid_o   = ov_q;
  assign covered_o     = cov_q;
  assign pixel_value_o = val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (up_ready_o) begin
      ov_q <= up_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_ready_o && up_valid_i) begin
      cov_q <= cov_d;
      val_q <= cov_d && sd.val;
    end
  end

endmodule
